FILE: hdl/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// Needs clk_i and rst_ni in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define HRBD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HRBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/hrbd_pkg.sv
// Types, constants and run-length tables of the Huffman/zero-run decoder.
// No dependencies.
package hrbd_pkg;

  localparam int unsigned MaxBlock       = 65536;
  localparam int unsigned TreeNodesDef   = 1024;
  localparam int unsigned MaxCodeBitsDef = 32;
  localparam int unsigned SymbolBits     = 9;
  localparam int unsigned RunBaseSymbol  = 256;
  localparam int unsigned LenW           = 17;

  typedef enum logic [3:0] {
    PH_MASTER, PH_HSIZE, PH_HCRC, PH_HMODE, PH_FILL, PH_COPY,
    PH_TFLAG, PH_TSYM, PH_WALK, PH_EXTRA, PH_DRAIN
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE, S_PRE, S_BIT, S_NEW, S_POP, S_LINK, S_WALK2, S_BLKDONE, S_END
  } ctrl_state_e;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_OK   = 2'd1,
    ST_FAIL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_CAPACITY, CFG_COPY_CODE, CFG_FILL_CODE, CFG_HUFF_CODE
  } cfg_index_e;

  typedef struct packed {
    logic [31:0] out_capacity;
    logic [7:0]  copy_code;
    logic [7:0]  fill_code;
    logic [7:0]  huff_code;
  } cfg_t;

  typedef struct packed {
    logic [7:0]      value;
    logic [LenW-1:0] run_length;
    status_e         status;
    logic            stream_end;
  } result_t;

  function automatic logic [8:0] run_base(input logic [2:0] k);
    case (k)
      3'd0:    return 9'd2;
      3'd1:    return 9'd3;
      3'd2:    return 9'd7;
      3'd3:    return 9'd23;
      default: return 9'd279;
    endcase
  endfunction

  function automatic logic [5:0] run_extra(input logic [2:0] k);
    case (k)
      3'd0:    return 6'd0;
      3'd1:    return 6'd2;
      3'd2:    return 6'd4;
      3'd3:    return 6'd8;
      default: return 6'd14;
    endcase
  endfunction

endpackage

FILE: hdl/hrbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hrbd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/hrbd_out.sv
// Output register stage of the decoder result channel.
// Depends on hrbd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module hrbd_out import hrbd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  result_t         result_i,
  output logic            free_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [7:0]      out_value_o,
  output logic [LenW-1:0] run_length_o,
  output logic [1:0]      status_o,
  output logic            stream_end_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_value_o  = data_q.value;
  assign run_length_o = data_q.run_length;
  assign status_o     = data_q.status;
  assign stream_end_o = data_q.stream_end;

  `HRBD_ASSERT(a_no_overrun, !(load_i && valid_q && !out_ready_i), "result beat overwritten")

endmodule

FILE: hdl/hrbd_core.sv
// Decoder sequencer: bit unpacking, headers, copy and fill blocks, tree build and tree walk.
// Depends on hrbd_pkg, hrbd_ram and assert_macros.svh.
`include "assert_macros.svh"
module hrbd_core import hrbd_pkg::*; #(
  parameter int unsigned TREE_NODES    = TreeNodesDef,
  parameter int unsigned MAX_CODE_BITS = MaxCodeBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       in_ready_o,
  input  logic       out_free_i,
  output logic       emit_o,
  output result_t    result_o
);

  localparam int unsigned IW  = $clog2(TREE_NODES);
  localparam int unsigned NW  = 1 + SymbolBits + IW;
  localparam int unsigned SD  = MAX_CODE_BITS + 1;
  localparam int unsigned SAW = $clog2(SD);
  localparam int unsigned DW  = $clog2(MAX_CODE_BITS + 2);

  ctrl_state_e state_q, state_d, tgt;
  phase_e      phase_q, phase_d, want_ph;
  logic [31:0] win_q, win_d, total_q, total_d, v;
  logic [5:0]  held_q, held_d, need_q, need_d, held_nx, want_n;
  logic [LenW-1:0] blk_q, blk_d, enc_q, enc_d, reach_q, reach_d, bl, zr_cnt;
  logic [IW-1:0] nc_q, nc_d, walk_q, walk_d, cur_child_q, cur_child_d;
  logic [IW-1:0] next_q, next_d, root_child_q, root_child_d, eff_child, node_nx;
  logic [IW:0]   nx_wide;
  logic [DW-1:0] depth_q, depth_d, depth_m1;
  logic [2:0]    tok_q, tok_d, bi_q, bi_d;
  logic [7:0]    byte_q, byte_d;
  logic          last_q, last_d, root_leaf_q, root_leaf_d;
  logic [SymbolBits-1:0] root_sym_q, root_sym_d, take_sym, rd_sym;
  logic [SD-1:0] flag_q, flag_d;
  logic          adv, fin, fin_ok, want_en, take_en, zr_en, step_go, bit_val, rd_leaf;
  logic [IW-1:0] rd_child;
  result_t       res;

  logic          node_we, stk_we;
  logic [IW-1:0] node_waddr, node_raddr;
  logic [NW-1:0] node_wdata, node_rdata;
  logic [SAW-1:0] stk_waddr, stk_raddr;
  logic [IW-1:0] stk_wdata, stk_rdata;

  hrbd_ram #(.Width(NW), .Depth(TREE_NODES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we && step_go),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  hrbd_ram #(.Width(IW), .Depth(SD)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we && step_go),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign bit_val    = byte_q[bi_q];
  assign v          = win_q | (32'(bit_val) << held_q);
  assign held_nx    = held_q + 6'd1;
  assign eff_child  = (walk_q == '0) ? root_child_q : cur_child_q;
  assign nx_wide    = bit_val ? {1'b0, eff_child} : ({1'b0, walk_q} + (IW+1)'(1));
  assign node_nx    = (nx_wide >= (IW+1)'(TREE_NODES)) ? '0 : nx_wide[IW-1:0];
  assign depth_m1   = depth_q - DW'(1);
  assign rd_leaf    = node_rdata[NW-1];
  assign rd_sym     = node_rdata[NW-2 -: SymbolBits];
  assign rd_child   = node_rdata[IW-1:0];
  assign bl         = (total_q < 32'(MaxBlock)) ? total_q[LenW-1:0] : LenW'(MaxBlock);
  assign step_go    = !emit_o || out_free_i;
  assign result_o   = res;

  always_comb begin : datapath
    phase_d = phase_q;   win_d = win_q;       held_d = held_q;   need_d = need_q;
    total_d = total_q;   blk_d = blk_q;       enc_d = enc_q;     reach_d = reach_q;
    nc_d = nc_q;         depth_d = depth_q;   walk_d = walk_q;   tok_d = tok_q;
    byte_d = byte_q;     last_d = last_q;     bi_d = bi_q;       next_d = next_q;
    cur_child_d = cur_child_q;  root_child_d = root_child_q;
    root_leaf_d = root_leaf_q;  root_sym_d = root_sym_q;  flag_d = flag_q;
    tgt = state_q;  adv = 1'b0;  fin = 1'b0;  fin_ok = 1'b0;
    want_en = 1'b0; want_ph = phase_q; want_n = need_q;
    take_en = 1'b0; take_sym = '0; zr_en = 1'b0; zr_cnt = '0;
    emit_o = 1'b0;  res = '0;
    node_we = 1'b0; node_waddr = nc_q; node_wdata = '0; node_raddr = next_q;
    stk_we = 1'b0;  stk_waddr = depth_q[SAW-1:0]; stk_wdata = nc_q - IW'(1);
    stk_raddr = depth_m1[SAW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          byte_d = in_byte_i;
          last_d = in_last_i;
          bi_d   = '0;
          if (phase_q == PH_DRAIN) begin
            if (in_last_i) begin
              phase_d = PH_MASTER;
            end
          end else begin
            tgt = S_PRE;
          end
        end
      end
      S_PRE: begin
        if (reach_q != '0) begin
          reach_d = reach_q - LenW'(1);
        end
        if (phase_q == PH_TFLAG || phase_q == PH_TSYM || phase_q == PH_WALK ||
            phase_q == PH_EXTRA) begin
          if (enc_q == '0) begin
            fin = 1'b1;
          end else begin
            enc_d = enc_q - LenW'(1);
          end
        end
        if (phase_q == PH_COPY) begin
          emit_o         = 1'b1;
          res.value      = byte_q;
          res.run_length = LenW'(1);
          res.status     = ST_DATA;
          blk_d          = blk_q - LenW'(1);
          tgt            = (blk_q == LenW'(1)) ? S_BLKDONE : S_END;
        end else begin
          tgt = S_BIT;
        end
      end
      S_BIT: begin
        if (held_nx < need_q) begin
          win_d  = v;
          held_d = held_nx;
          adv    = 1'b1;
        end else begin
          win_d  = '0;
          held_d = '0;
          unique case (phase_q)
            PH_MASTER: begin
              if (v > cfg_i.out_capacity) begin
                fin = 1'b1;
              end else begin
                total_d = v;
                if (v == '0) begin
                  tgt = S_BLKDONE;
                end else begin
                  want_en = 1'b1; want_ph = PH_HSIZE; want_n = 6'd16; adv = 1'b1;
                end
              end
            end
            PH_HSIZE: begin
              enc_d   = LenW'(v[15:0]) + LenW'(1);
              want_en = 1'b1; want_ph = PH_HCRC; want_n = 6'd32; adv = 1'b1;
            end
            PH_HCRC: begin
              want_en = 1'b1; want_ph = PH_HMODE; want_n = 6'd8; adv = 1'b1;
            end
            PH_HMODE: begin
              blk_d   = bl;
              total_d = total_q - 32'(bl);
              priority if (v[7:0] == cfg_i.copy_code) begin
                if (enc_q != bl) begin
                  fin = 1'b1;
                end else begin
                  enc_d   = '0;
                  want_en = 1'b1; want_ph = PH_COPY; want_n = 6'd8; adv = 1'b1;
                end
              end else if (v[7:0] == cfg_i.fill_code) begin
                enc_d   = '0;
                want_en = 1'b1; want_ph = PH_FILL; want_n = 6'd8; adv = 1'b1;
              end else if (v[7:0] == cfg_i.huff_code) begin
                if (enc_q > reach_q) begin
                  reach_d = enc_q;
                end
                nc_d    = '0;
                depth_d = '0;
                tgt     = S_NEW;
              end else begin
                fin = 1'b1;
              end
            end
            PH_FILL: begin
              emit_o         = 1'b1;
              res.value      = v[7:0];
              res.run_length = blk_q;
              res.status     = ST_DATA;
              blk_d          = '0;
              tgt            = S_BLKDONE;
            end
            PH_TFLAG: begin
              if (v[0]) begin
                want_en = 1'b1; want_ph = PH_TSYM; want_n = 6'(SymbolBits); adv = 1'b1;
              end else begin
                stk_we                      = 1'b1;
                flag_d[depth_q[SAW-1:0]]    = 1'b0;
                depth_d                     = depth_q + DW'(1);
                tgt                         = S_NEW;
              end
            end
            PH_TSYM: begin
              node_we    = 1'b1;
              node_waddr = nc_q - IW'(1);
              node_wdata = {1'b1, v[SymbolBits-1:0], IW'(0)};
              if (nc_q == IW'(1)) begin
                root_leaf_d = 1'b1;
                root_sym_d  = v[SymbolBits-1:0];
              end
              tgt = S_POP;
            end
            PH_WALK: begin
              if (root_leaf_q) begin
                take_en  = 1'b1;
                take_sym = root_sym_q;
              end else begin
                node_raddr = node_nx;
                next_d     = node_nx;
                tgt        = S_WALK2;
              end
            end
            PH_EXTRA: begin
              zr_en  = 1'b1;
              zr_cnt = LenW'(v[13:0]) + LenW'(run_base(tok_q));
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_NEW: begin
        if (({1'b0, nc_q} + (IW+1)'(1)) >= (IW+1)'(TREE_NODES) ||
            depth_q > DW'(MAX_CODE_BITS)) begin
          fin = 1'b1;
        end else begin
          node_we    = 1'b1;
          node_waddr = nc_q;
          node_wdata = '0;
          if (nc_q == '0) begin
            root_leaf_d  = 1'b0;
            root_sym_d   = '0;
            root_child_d = '0;
          end
          nc_d    = nc_q + IW'(1);
          want_en = 1'b1; want_ph = PH_TFLAG; want_n = 6'd1; adv = 1'b1;
        end
      end
      S_POP: begin
        if (depth_q != '0 && flag_q[depth_m1[SAW-1:0]]) begin
          depth_d = depth_m1;
        end else if (depth_q == '0) begin
          walk_d  = '0;
          want_en = 1'b1; want_ph = PH_WALK; want_n = 6'd1; adv = 1'b1;
        end else begin
          flag_d[depth_m1[SAW-1:0]] = 1'b1;
          tgt = S_LINK;
        end
      end
      S_LINK: begin
        node_we    = 1'b1;
        node_waddr = stk_rdata;
        node_wdata = {1'b0, SymbolBits'(0), nc_q};
        if (stk_rdata == '0) begin
          root_child_d = nc_q;
        end
        tgt = S_NEW;
      end
      S_WALK2: begin
        if (rd_leaf) begin
          take_en  = 1'b1;
          take_sym = rd_sym;
        end else begin
          walk_d      = next_q;
          cur_child_d = rd_child;
          adv         = 1'b1;
        end
      end
      S_BLKDONE: begin
        if (total_q == '0) begin
          fin    = 1'b1;
          fin_ok = last_q && (reach_q == '0);
        end else begin
          want_en = 1'b1; want_ph = PH_HSIZE; want_n = 6'd16;
          tgt     = S_END;
        end
      end
      S_END: begin
        if (last_q) begin
          fin = 1'b1;
        end else begin
          tgt = S_IDLE;
        end
      end
      default: begin
        tgt = S_IDLE;
      end
    endcase

    if (take_en) begin
      priority if (!take_sym[SymbolBits-1]) begin
        emit_o         = 1'b1;
        res.value      = take_sym[7:0];
        res.run_length = LenW'(1);
        res.status     = ST_DATA;
        blk_d          = blk_q - LenW'(1);
        walk_d         = '0;
        want_en = 1'b1; want_ph = PH_WALK; want_n = 6'd1;
        if (blk_q == LenW'(1)) begin
          tgt = S_BLKDONE;
        end else begin
          adv = 1'b1;
        end
      end else if (take_sym == SymbolBits'(RunBaseSymbol)) begin
        zr_en  = 1'b1;
        zr_cnt = LenW'(run_base(3'd0));
      end else if (take_sym <= SymbolBits'(RunBaseSymbol + 4)) begin
        tok_d   = take_sym[2:0];
        want_en = 1'b1; want_ph = PH_EXTRA; want_n = run_extra(take_sym[2:0]); adv = 1'b1;
      end else begin
        fin = 1'b1;
      end
    end

    if (zr_en) begin
      if (zr_cnt > blk_q) begin
        fin = 1'b1;
      end else begin
        emit_o         = 1'b1;
        res.value      = '0;
        res.run_length = zr_cnt;
        res.status     = ST_DATA;
        blk_d          = blk_q - zr_cnt;
        walk_d         = '0;
        want_en = 1'b1; want_ph = PH_WALK; want_n = 6'd1;
        if (blk_q == zr_cnt) begin
          tgt = S_BLKDONE;
        end else begin
          adv = 1'b1;
        end
      end
    end

    if (want_en) begin
      phase_d = want_ph;
      need_d  = want_n;
      win_d   = '0;
      held_d  = '0;
    end

    if (adv) begin
      if (bi_q == 3'd7) begin
        tgt = S_END;
      end else begin
        bi_d = bi_q + 3'd1;
        tgt  = S_BIT;
      end
    end

    if (fin) begin
      emit_o         = 1'b1;
      res.value      = '0;
      res.run_length = '0;
      res.status     = fin_ok ? ST_OK : ST_FAIL;
      res.stream_end = 1'b1;
      phase_d = last_q ? PH_MASTER : PH_DRAIN;
      need_d  = 6'd32;  win_d  = '0;  held_d  = '0;
      total_d = '0;     blk_d  = '0;  enc_d   = '0;  reach_d = '0;
      nc_d    = '0;     depth_d = '0; walk_d  = '0;  tok_d   = '0;
      tgt     = S_IDLE;
    end
  end

  always_comb begin : next_state
    state_d = step_go ? tgt : state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;      phase_q <= PH_MASTER;
      win_q <= '0;  held_q <= '0;  need_q <= 6'd32;
      total_q <= '0; blk_q <= '0;  enc_q <= '0;  reach_q <= '0;
      nc_q <= '0;   depth_q <= '0; walk_q <= '0; tok_q <= '0;
      byte_q <= '0; last_q <= 1'b0; bi_q <= '0;  next_q <= '0;
      cur_child_q <= '0; root_child_q <= '0; root_leaf_q <= 1'b0; root_sym_q <= '0;
      flag_q <= '0;
    end else begin
      state_q <= state_d;
      if (step_go) begin
        phase_q <= phase_d;  win_q <= win_d;  held_q <= held_d;  need_q <= need_d;
        total_q <= total_d;  blk_q <= blk_d;  enc_q <= enc_d;    reach_q <= reach_d;
        nc_q <= nc_d;        depth_q <= depth_d; walk_q <= walk_d; tok_q <= tok_d;
        byte_q <= byte_d;    last_q <= last_d;   bi_q <= bi_d;     next_q <= next_d;
        cur_child_q <= cur_child_d;  root_child_q <= root_child_d;
        root_leaf_q <= root_leaf_d;  root_sym_q <= root_sym_d;
        flag_q <= flag_d;
      end
    end
  end

  `HRBD_ASSERT(a_depth_bound, depth_q <= DW'(MAX_CODE_BITS + 1), "tree stack too deep")
  `HRBD_ASSERT(a_node_bound, {1'b0, nc_q} < (IW+1)'(TREE_NODES), "node count out of range")
  `HRBD_ASSERT_NEXT(a_end_idle, emit_o && step_go && res.stream_end, state_q == S_IDLE, "no idle after stream end")

endmodule

FILE: hdl/huffman_rle_block_decoder.sv
// Top level of the Huffman/zero-run block decoder: config registers, core, output stage.
// Depends on hrbd_pkg, hrbd_core and hrbd_out.
//
//  channel | direction | handshake               | payload
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i/in_ready_o   | in_byte_i, in_last_i
//  out     | out       | out_valid_o/out_ready_i | out_value_o, run_length_o, status_o, stream_end_o
//
// A byte passes S_IDLE and S_PRE, then S_BIT for each bit it consumes, and normally S_END; a
// tree walk bit adds S_WALK2 for the node memory read, which a single leaf tree skips, and a
// byte that closes a block adds S_BLKDONE. Tree building adds S_NEW per node, S_POP and
// S_LINK per back link and S_POP per stack pop. Copy bytes skip S_BIT. No clearing pass
// after reset. A result beat waiting in the output register stalls the core only when it
// must emit again.
module huffman_rle_block_decoder import hrbd_pkg::*; #(
  parameter int unsigned TREE_NODES    = TreeNodesDef,
  parameter int unsigned MAX_CODE_BITS = MaxCodeBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [31:0]     cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_value_o,
  output logic [LenW-1:0] run_length_o,
  output logic [1:0]      status_o,
  output logic            stream_end_o
);

  cfg_t    cfg_q, cfg_d;
  logic    emit, out_free;
  result_t result;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_CAPACITY:  cfg_d.out_capacity = cfg_data_i;
        CFG_COPY_CODE: cfg_d.copy_code    = cfg_data_i[7:0];
        CFG_FILL_CODE: cfg_d.fill_code    = cfg_data_i[7:0];
        CFG_HUFF_CODE: cfg_d.huff_code    = cfg_data_i[7:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.out_capacity <= 32'hFFFF_FFFF;
      cfg_q.copy_code    <= 8'd0;
      cfg_q.fill_code    <= 8'd1;
      cfg_q.huff_code    <= 8'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hrbd_core #(
    .TREE_NODES    (TREE_NODES),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .emit_o     (emit),
    .result_o   (result)
  );

  hrbd_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (emit && out_free),
    .result_i     (result),
    .free_o       (out_free),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_value_o  (out_value_o),
    .run_length_o (run_length_o),
    .status_o     (status_o),
    .stream_end_o (stream_end_o)
  );

endmodule

FILE: bench/huffman_rle_block_decoder_tb.sv
// Self-checking testbench for huffman_rle_block_decoder: builds compressed streams,
// drives them through the byte channel and checks every result beat.
// Depends on hrbd_pkg and the decoder RTL.
module huffman_rle_block_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hrbd_pkg::*;

  localparam int unsigned LeafFlag  = 32'h200000;
  localparam int unsigned InBFlag   = 32'h1000;
  localparam int unsigned ChildMask = 32'hFFF;
  localparam int unsigned SymMask   = 32'h1FF;
  localparam int unsigned SymShift  = 12;
  localparam int unsigned MaxBeats  = 9;
  localparam int          DrainWait = 64;
  localparam int          StallLimit = 20000;

  typedef enum {M_COPY, M_FILL, M_HUFF} mode_sel_e;
  typedef enum {
    K_PLAIN, K_TOKENS, K_SINGLE, K_FLIP, K_CUT, K_TRAIL, K_BADMODE, K_COPYSIZE,
    K_OVERREAD, K_UNDERREAD, K_BADTOK, K_RUNOVF, K_LONGCODE, K_BIGTREE
  } kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_beat_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [1:0]      cfg_index_i = '0;
  logic [31:0]     cfg_data_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [7:0]      in_byte_i = '0;
  logic            in_last_i = 1'b0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [7:0]      out_value_o;
  logic [LenW-1:0] run_length_o;
  logic [1:0]      status_o;
  logic            stream_end_o;

  huffman_rle_block_decoder u_top (.*);

  initial forever #5 clk_i = ~clk_i;

  // ---------------- decoder prediction ----------------
  logic [31:0] cap_r, copy_r, fill_r, huff_r;
  phase_e      dec_phase;
  int unsigned win, held, need;
  int unsigned total_left, block_left, enc_left, reach_left;
  int unsigned node_store [TreeNodesDef];
  int unsigned build_stack [MaxCodeBitsDef+1];
  int unsigned nodes_used, stack_depth, walk_node, pending_tok;
  bit          cur_last, stop_byte, ended;
  int          beats_now;
  result_t     expected_q [$];
  int unsigned zr_base [5] = '{2, 3, 7, 23, 279};
  int unsigned zr_extra [5] = '{0, 2, 4, 8, 14};

  function automatic void post(logic [7:0] v, int unsigned len, status_e st, logic e);
    result_t r;
    if (beats_now >= MaxBeats) return;
    r.value = v;
    r.run_length = len[LenW-1:0];
    r.status = st;
    r.stream_end = e;
    expected_q.push_back(r);
    beats_now++;
  endfunction

  function automatic void need_bits(phase_e p, int unsigned n);
    dec_phase = p;
    need = n;
    win = 0;
    held = 0;
  endfunction

  function automatic void restart();
    need_bits(PH_MASTER, 32);
    total_left = 0; block_left = 0; enc_left = 0; reach_left = 0;
    nodes_used = 0; stack_depth = 0; walk_node = 0; pending_tok = 0;
  endfunction

  function automatic void close_stream(bit ok);
    post(8'd0, 0, ok ? ST_OK : ST_FAIL, 1'b1);
    restart();
    if (!cur_last) dec_phase = PH_DRAIN;
    stop_byte = 1;
    ended = 1;
  endfunction

  function automatic void end_block();
    if (total_left == 0) begin
      close_stream(cur_last && reach_left == 0);
    end else begin
      need_bits(PH_HSIZE, 16);
      stop_byte = 1;
    end
  endfunction

  function automatic void alloc_node();
    if (nodes_used + 1 >= TreeNodesDef || stack_depth > MaxCodeBitsDef) begin
      close_stream(0);
      return;
    end
    node_store[nodes_used] = 0;
    nodes_used++;
    need_bits(PH_TFLAG, 1);
  endfunction

  function automatic void emit_zeros(int unsigned cnt);
    if (cnt > block_left) begin
      close_stream(0);
      return;
    end
    post(8'd0, cnt, ST_DATA, 1'b0);
    block_left -= cnt;
    walk_node = 0;
    need_bits(PH_WALK, 1);
    if (block_left == 0) end_block();
  endfunction

  function automatic void take_sym(int unsigned s);
    if (s < RunBaseSymbol) begin
      post(s[7:0], 1, ST_DATA, 1'b0);
      block_left--;
      walk_node = 0;
      need_bits(PH_WALK, 1);
      if (block_left == 0) end_block();
    end else if (s == RunBaseSymbol) begin
      emit_zeros(zr_base[0]);
    end else if (s <= RunBaseSymbol + 4) begin
      pending_tok = s;
      need_bits(PH_EXTRA, zr_extra[s - RunBaseSymbol]);
    end else begin
      close_stream(0);
    end
  endfunction

  function automatic void shift_bit(int unsigned b);
    int unsigned v, nxt, top, k;
    win |= b << held;
    held++;
    if (held < need) return;
    v = win;
    win = 0;
    held = 0;
    case (dec_phase)
      PH_MASTER: begin
        if (v > cap_r) begin
          close_stream(0);
          return;
        end
        total_left = v;
        if (total_left == 0) end_block();
        else need_bits(PH_HSIZE, 16);
      end
      PH_HSIZE: begin
        enc_left = v + 1;
        need_bits(PH_HCRC, 32);
      end
      PH_HCRC: need_bits(PH_HMODE, 8);
      PH_HMODE: begin
        block_left = total_left < MaxBlock ? total_left : MaxBlock;
        total_left -= block_left;
        if (v == copy_r) begin
          if (enc_left != block_left) begin
            close_stream(0);
            return;
          end
          enc_left = 0;
          need_bits(PH_COPY, 8);
        end else if (v == fill_r) begin
          enc_left = 0;
          need_bits(PH_FILL, 8);
        end else if (v == huff_r) begin
          if (enc_left > reach_left) reach_left = enc_left;
          nodes_used = 0;
          stack_depth = 0;
          alloc_node();
        end else begin
          close_stream(0);
        end
      end
      PH_FILL: begin
        post(v[7:0], block_left, ST_DATA, 1'b0);
        block_left = 0;
        end_block();
      end
      PH_TFLAG: begin
        if (v != 0) begin
          need_bits(PH_TSYM, SymbolBits);
        end else begin
          build_stack[stack_depth] = nodes_used - 1;
          stack_depth++;
          alloc_node();
        end
      end
      PH_TSYM: begin
        node_store[nodes_used-1] = LeafFlag | ((v & SymMask) << SymShift);
        while (stack_depth > 0 && (build_stack[stack_depth-1] & InBFlag) != 0)
          stack_depth--;
        if (stack_depth == 0) begin
          walk_node = 0;
          need_bits(PH_WALK, 1);
        end else begin
          build_stack[stack_depth-1] |= InBFlag;
          top = build_stack[stack_depth-1] & ChildMask;
          if (top < TreeNodesDef) node_store[top] |= nodes_used;
          alloc_node();
        end
      end
      PH_WALK: begin
        if ((node_store[0] & LeafFlag) != 0) begin
          take_sym((node_store[0] >> SymShift) & SymMask);
        end else begin
          nxt = (v != 0) ? (node_store[walk_node] & ChildMask) : walk_node + 1;
          if (nxt >= TreeNodesDef) nxt = 0;
          if ((node_store[nxt] & LeafFlag) != 0)
            take_sym((node_store[nxt] >> SymShift) & SymMask);
          else
            walk_node = nxt;
        end
      end
      PH_EXTRA: begin
        k = pending_tok - RunBaseSymbol;
        if (k < 1 || k > 4) begin
          close_stream(0);
          return;
        end
        emit_zeros(v + zr_base[k]);
      end
      default: close_stream(0);
    endcase
  endfunction

  function automatic void predict_beat(logic [7:0] b, logic last);
    beats_now = 0;
    stop_byte = 0;
    ended = 0;
    cur_last = last;
    if (dec_phase == PH_DRAIN) begin
      if (cur_last) restart();
      return;
    end
    if (reach_left > 0) reach_left--;
    if (dec_phase inside {PH_TFLAG, PH_TSYM, PH_WALK, PH_EXTRA}) begin
      if (enc_left == 0) begin
        close_stream(0);
        return;
      end
      enc_left--;
    end
    if (dec_phase == PH_COPY) begin
      post(b, 1, ST_DATA, 1'b0);
      block_left--;
      if (block_left == 0) end_block();
    end else begin
      for (int i = 0; i < 8 && !stop_byte; i++) shift_bit(b[i]);
    end
    if (!ended && cur_last) close_stream(0);
  endfunction

  // ---------------- stream construction ----------------
  in_beat_t    pending_q [$];
  int unsigned leaf_sym [512];
  int          n_leaves, tree_depth;
  bit          full_tree;
  int          err_cnt, n_in, n_out, n_streams;
  int          send_idle_pct, recv_stall_pct, idle_cycles;
  bit          hold_send;

  function automatic void put(ref bit q[$], input longint unsigned v, input int n);
    for (int i = 0; i < n; i++) q.push_back(v[i]);
  endfunction

  function automatic void put_code(ref bit q[$], input int leaf);
    if (full_tree) begin
      for (int i = tree_depth - 1; i >= 0; i--) q.push_back(leaf[i]);
    end else if (n_leaves == 1) begin
      q.push_back(1'($urandom_range(1)));
    end else begin
      for (int i = 0; i < leaf; i++) q.push_back(1'b1);
      if (leaf < n_leaves - 1) q.push_back(1'b0);
    end
  endfunction

  function automatic int unsigned unused_mode();
    int unsigned v;
    do v = $urandom_range(255); while (v == copy_r || v == fill_r || v == huff_r);
    return v;
  endfunction

  task automatic build_huff(ref bit b[$], input int unsigned blk, input kind_e kd);
    int unsigned rem, s, k, x, e, z;
    int leaf;
    full_tree = 0;
    if (kd == K_LONGCODE) begin
      n_leaves = 34;
    end else if (kd == K_BIGTREE) begin
      full_tree = 1;
      tree_depth = 9;
    end else if (kd == K_SINGLE) begin
      n_leaves = 1;
    end else if (kd == K_TOKENS) begin
      n_leaves = 6;
    end else if ($urandom_range(2) == 0) begin
      full_tree = 1;
      tree_depth = $urandom_range(3, 1);
    end else begin
      n_leaves = $urandom_range(8, 2);
    end
    if (full_tree) n_leaves = 1 << tree_depth;
    for (int i = 0; i < n_leaves; i++)
      leaf_sym[i] = ($urandom_range(2) == 0 && i > 0) ? RunBaseSymbol + $urandom_range(4)
                                                    : $urandom_range(255);
    if (kd == K_TOKENS)
      for (int i = 1; i < 6; i++) leaf_sym[i] = RunBaseSymbol + i - 1;
    if (kd == K_BADTOK) leaf_sym[n_leaves-1] = $urandom_range(SymMask, RunBaseSymbol + 5);
    if (kd == K_RUNOVF) leaf_sym[n_leaves-1] = RunBaseSymbol + 4;
    if (full_tree) begin
      for (int j = 0; j < n_leaves; j++) begin
        z = 0;
        if (j == 0) z = tree_depth;
        else while (((j >> z) & 1) == 0) z++;
        put(b, 0, z);
        put(b, 1, 1);
        put(b, leaf_sym[j], SymbolBits);
      end
    end else begin
      for (int j = 0; j < n_leaves; j++) begin
        if (j < n_leaves - 1) put(b, 0, 1);
        put(b, 1, 1);
        put(b, leaf_sym[j], SymbolBits);
      end
    end
    if (kd == K_LONGCODE || kd == K_BIGTREE) begin
      put(b, $urandom, 8);
    end else begin
      rem = blk;
      while (rem > 0) begin
        if (kd == K_BADTOK && ($urandom_range(3) == 0 || rem == 1)) begin
          put_code(b, n_leaves - 1);
          break;
        end
        if (kd == K_RUNOVF && ($urandom_range(3) == 0 || rem <= 2)) begin
          put_code(b, n_leaves - 1);
          put(b, $urandom, zr_extra[4]);
          break;
        end
        leaf = $urandom_range(n_leaves - 1);
        s = leaf_sym[leaf];
        if (s > RunBaseSymbol + 4 || (s >= RunBaseSymbol && zr_base[s-RunBaseSymbol] > rem))
        begin
          leaf = 0;
          s = leaf_sym[0];
        end
        put_code(b, leaf);
        if (s < RunBaseSymbol) begin
          rem--;
        end else begin
          k = s - RunBaseSymbol;
          x = (1 << zr_extra[k]) - 1;
          if (x > rem - zr_base[k]) x = rem - zr_base[k];
          e = $urandom_range(x);
          put(b, e, zr_extra[k]);
          rem -= zr_base[k] + e;
        end
      end
    end
    while (b.size() % 8 != 0) b.push_back(1'($urandom_range(1)));
  endtask

  task automatic gen_stream(mode_sel_e m, int unsigned total, kind_e kd);
    bit          s [$];
    bit          b [$];
    in_beat_t    bq [$];
    in_beat_t    nb;
    int unsigned left, blk, enc, mode_byte, n;
    put(s, total, 32);
    left = total;
    while (left > 0) begin
      blk = left < MaxBlock ? left : MaxBlock;
      left -= blk;
      b.delete();
      case (m)
        M_COPY: begin
          for (int i = 0; i < blk; i++) put(b, $urandom, 8);
          enc = (kd == K_COPYSIZE) ? blk + 1 : blk;
          mode_byte = copy_r;
        end
        M_FILL: begin
          put(b, $urandom, 8);
          enc = $urandom_range(MaxBlock, 1);
          mode_byte = fill_r;
        end
        default: begin
          build_huff(b, blk, kd);
          enc = b.size() / 8;
          if (kd == K_OVERREAD && enc > 1) enc--;
          if (kd == K_UNDERREAD) enc++;
          mode_byte = huff_r;
        end
      endcase
      if (kd == K_BADMODE) mode_byte = unused_mode();
      put(s, enc - 1, 16);
      put(s, $urandom, 32);
      put(s, mode_byte, 8);
      s = {s, b};
    end
    for (int i = 0; i < s.size(); i += 8) begin
      for (int j = 0; j < 8; j++) nb.data[j] = s[i+j];
      nb.last = 1'b0;
      bq.push_back(nb);
    end
    if (kd == K_FLIP) bq[$urandom_range(bq.size()-1)].data[$urandom_range(7)] ^= 1'b1;
    if (kd == K_CUT && bq.size() > 1) begin
      n = $urandom_range(bq.size() - 1, 1);
      while (bq.size() > n) void'(bq.pop_back());
    end
    if (kd == K_TRAIL) begin
      n = $urandom_range(3, 1);
      for (int i = 0; i < n; i++) begin
        nb.data = 8'($urandom);
        bq.push_back(nb);
      end
    end
    bq[bq.size()-1].last = 1'b1;
    pending_q = {pending_q, bq};
    n_streams++;
  endtask

  task automatic random_streams(int unsigned n_bytes);
    int unsigned sent, total;
    mode_sel_e   m;
    kind_e       kd;
    in_beat_t    nb;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(15) == 0) begin
        nb.data = 8'($urandom);
        nb.last = 1'($urandom_range(1));
        pending_q.push_back(nb);
        sent++;
        continue;
      end
      m = mode_sel_e'($urandom_range(2));
      kd = ($urandom_range(99) < 65) ? K_PLAIN : kind_e'($urandom_range(K_BIGTREE - 1, 1));
      case (m)
        M_COPY: total = $urandom_range(12, 1);
        M_FILL: total = ($urandom_range(19) == 0) ? $urandom_range(70000, 60000)
                                                   : $urandom_range(300, 1);
        default: total = ($urandom_range(9) == 0) ? $urandom_range(120, 60)
                                                   : $urandom_range(40, 1);
      endcase
      if ($urandom_range(30) == 0) total = 0;
      if (kd == K_BIGTREE && $urandom_range(3) != 0) kd = K_PLAIN;
      sent -= pending_q.size();
      gen_stream(m, total, kd);
      sent += pending_q.size();
    end
  endtask

  task automatic cfg_write(cfg_index_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_CAPACITY:  cap_r = val;
      CFG_COPY_CODE: copy_r = val[7:0];
      CFG_FILL_CODE: fill_r = val[7:0];
      default:       huff_r = val[7:0];
    endcase
  endtask

  task automatic set_codes(logic [31:0] cap, logic [7:0] cc, logic [7:0] fc, logic [7:0] hc);
    cfg_write(CFG_CAPACITY, cap);
    cfg_write(CFG_COPY_CODE, {24'd0, cc});
    cfg_write(CFG_FILL_CODE, {24'd0, fc});
    cfg_write(CFG_HUFF_CODE, {24'd0, hc});
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // ---------------- byte driver ----------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_beat(in_byte_i, in_last_i);
        n_in++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_q.size() != 0 && !hold_send && $urandom_range(99) >= send_idle_pct) begin
          in_beat_t nb;
          nb = pending_q.pop_front();
          in_valid_i <= 1'b1;
          in_byte_i <= nb.data;
          in_last_i <= nb.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------- result monitor and watchdog ----------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      idle_cycles <= 0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid_o && out_ready_i) begin
        n_out++;
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: value %0d run %0d status %0d end %0b",
                 out_value_o, run_length_o, status_o, stream_end_o);
          err_cnt++;
        end else begin
          result_t r;
          r = expected_q.pop_front();
          if (out_value_o !== r.value) begin
            $error("out_value: expected %0d, got %0d", r.value, out_value_o);
            err_cnt++;
          end
          if (run_length_o !== r.run_length) begin
            $error("run_length: expected %0d, got %0d", r.run_length, run_length_o);
            err_cnt++;
          end
          if (status_o !== r.status) begin
            $error("status: expected %0d, got %0d", r.status, status_o);
            err_cnt++;
          end
          if (stream_end_o !== r.stream_end) begin
            $error("stream_end: expected %0b, got %0b", r.stream_end, stream_end_o);
            err_cnt++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("watchdog: no beat for %0d cycles", StallLimit);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    cap_r = 32'hFFFF_FFFF;
    copy_r = 0;
    fill_r = 1;
    huff_r = 2;
    foreach (node_store[i]) node_store[i] = 0;
    foreach (build_stack[i]) build_stack[i] = 0;
    restart();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no idling, default codes, directed streams, then random ones
    set_codes(32'hFFFF_FFFF, 8'd0, 8'd1, 8'd2);
    gen_stream(M_FILL, 0, K_PLAIN);
    gen_stream(M_FILL, 65536, K_PLAIN);
    gen_stream(M_FILL, 70000, K_PLAIN);
    gen_stream(M_COPY, 4, K_PLAIN);
    gen_stream(M_COPY, 4, K_COPYSIZE);
    gen_stream(M_COPY, 3, K_BADMODE);
    gen_stream(M_HUFF, 600, K_TOKENS);
    gen_stream(M_HUFF, 8, K_SINGLE);
    gen_stream(M_HUFF, 5, K_LONGCODE);
    gen_stream(M_HUFF, 12, K_BADTOK);
    gen_stream(M_HUFF, 12, K_RUNOVF);
    gen_stream(M_HUFF, 8, K_OVERREAD);
    gen_stream(M_HUFF, 8, K_UNDERREAD);
    gen_stream(M_HUFF, 8, K_CUT);
    gen_stream(M_HUFF, 8, K_TRAIL);
    random_streams(20);
    wait_idle();

    // sender idles, small capacity
    send_idle_pct = 61;
    set_codes(32'd200, 8'd255, 8'd128, 8'd0);
    gen_stream(M_FILL, 201, K_PLAIN);
    random_streams(10);
    hold_send = 1;
    while (in_valid_i || expected_q.size() != 0) @(posedge clk_i);
    hold_send = 0;
    random_streams(10);
    wait_idle();

    // receiver stalls
    send_idle_pct = 0;
    recv_stall_pct = 61;
    set_codes(32'hFFFF_FFFF, 8'd7, 8'd200, 8'd255);
    random_streams(20);
    wait_idle();

    // both sides idle; zero capacity first
    send_idle_pct = 10;
    recv_stall_pct = 10;
    cfg_write(CFG_CAPACITY, 32'd0);
    gen_stream(M_FILL, 0, K_PLAIN);
    gen_stream(M_FILL, 1, K_PLAIN);
    wait_idle();
    set_codes($urandom_range(5000, 300), 8'd3, 8'd4, 8'd5);
    random_streams(20);
    wait_idle();

    $display("ran %0d streams: %0d input bytes, %0d result beats", n_streams, n_in, n_out);
    $display("copy, fill and Huffman blocks, error cases, four code settings, idle mixes");
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
